// ===== rtl/partial_permutation_rank_codec_defines.svh =====
// Assertion macros shared by the partial permutation rank codec RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef PARTIAL_PERMUTATION_RANK_CODEC_DEFINES_SVH
`define PARTIAL_PERMUTATION_RANK_CODEC_DEFINES_SVH

// Same-cycle implication.
`define PPR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PPR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ppr_pkg.sv =====
// Shared widths, lane result structs and the popcount helper for the rank codec.
// No dependencies; every other RTL module imports it.
package ppr_pkg;

   localparam int CELLS_DEFAULT = 16;
   localparam int NIB_W         = 4;
   localparam int LANES         = 16;
   localparam int MASK_W        = 16;
   localparam int COUNT_W       = 5;
   localparam int POS_W         = LANES * NIB_W;
   localparam int RANK_W        = 45;
   localparam int RANK_PAD_W    = 48;
   localparam int DIV_CHUNK_W   = 16;
   localparam int DIV_ROUNDS    = RANK_PAD_W / DIV_CHUNK_W;
   localparam int REQ_DATA_W    = 120;
   localparam int RSP_DATA_W    = 112;

   typedef struct packed {
      logic [POS_W-1:0] digits;
      logic             bad;
   } rank_lanes_type;

   typedef struct packed {
      logic [NIB_W-1:0]  pos;
      logic [MASK_W-1:0] onehot;
   } pick_type;

   function automatic logic [COUNT_W-1:0] pop16(input logic [MASK_W-1:0] v);
      logic [1:0] s1 [8];
      logic [2:0] s2 [4];
      logic [3:0] s3 [2];
      for (int k = 0; k < 8; k++) s1[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
      for (int k = 0; k < 4; k++) s2[k] = {1'b0, s1[2*k]} + {1'b0, s1[2*k+1]};
      for (int k = 0; k < 2; k++) s3[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
      return {1'b0, s3[0]} + {1'b0, s3[1]};
   endfunction

endpackage

// ===== rtl/ppr_rank_lanes.sv =====
// Rank-mode lanes: one lane per position computes its Lehmer digit and checks.
// Depends on ppr_pkg for widths, pop16 and rank_lanes_type.
module ppr_rank_lanes #(
   parameter int CELLS = ppr_pkg::CELLS_DEFAULT
) (
   input  logic [ppr_pkg::POS_W-1:0]   cells,
   input  logic [ppr_pkg::COUNT_W-1:0] count,
   output ppr_pkg::rank_lanes_type     lanes
);
   import ppr_pkg::*;

   localparam logic [COUNT_W-1:0] CellsN = COUNT_W'(CELLS);

   logic [NIB_W-1:0]  pos   [LANES];
   logic [MASK_W-1:0] hot   [LANES];
   logic [LANES-1:0]  col   [MASK_W];
   logic [MASK_W-1:0] prior [LANES];
   logic [LANES-1:0]  flag;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         pos[i] = cells[i*NIB_W +: NIB_W];
         hot[i] = MASK_W'(1) << pos[i];
      end
      for (int b = 0; b < MASK_W; b++) begin
         for (int i = 0; i < LANES; i++) col[b][i] = hot[i][b];
      end
      // cells used by earlier lanes, as a reduction per bit
      for (int i = 0; i < LANES; i++) begin
         for (int b = 0; b < MASK_W; b++) begin
            prior[i][b] = |(col[b] & ((LANES'(1) << i) - LANES'(1)));
         end
      end
      lanes.digits = '0;
      for (int i = 0; i < LANES; i++) begin
         lanes.digits[i*NIB_W +: NIB_W] =
            pos[i] - NIB_W'(pop16(prior[i] & (hot[i] - MASK_W'(1))));
         flag[i] = (COUNT_W'(i) < count) &&
                   ((|(prior[i] & hot[i])) || ({1'b0, pos[i]} >= CellsN));
      end
      lanes.bad = |flag;
   end

endmodule

// ===== rtl/ppr_div_step.sv =====
// One round of the small-divisor divider: four quotient nibbles per call,
// each found by sixteen compare lanes against the divisor's multiples.
// Depends on ppr_pkg for widths.
module ppr_div_step (
   input  logic [ppr_pkg::NIB_W-1:0]       rem_in,
   input  logic [ppr_pkg::DIV_CHUNK_W-1:0] chunk,
   input  logic [ppr_pkg::COUNT_W-1:0]     divisor,
   output logic [ppr_pkg::NIB_W-1:0]       rem_out,
   output logic [ppr_pkg::DIV_CHUNK_W-1:0] quo
);
   import ppr_pkg::*;

   localparam int Digits = DIV_CHUNK_W / NIB_W;
   localparam int Radix  = 1 << NIB_W;
   localparam int ValW   = 2 * NIB_W;

   logic [ValW-1:0]  mult [Radix];
   logic [ValW-1:0]  part;
   logic [ValW-1:0]  sub;
   logic [NIB_W-1:0] rem;
   logic [NIB_W-1:0] q;

   always_comb begin
      for (int m = 0; m < Radix; m++) mult[m] = ValW'(m * divisor);
      rem  = rem_in;
      quo  = '0;
      part = '0;
      sub  = '0;
      q    = '0;
      for (int s = 0; s < Digits; s++) begin
         part = {rem, chunk[DIV_CHUNK_W-1-s*NIB_W -: NIB_W]};
         q    = '0;
         sub  = '0;
         // multiples rise with m, so the last hit is the quotient digit
         for (int m = 0; m < Radix; m++) begin
            if (part >= mult[m]) begin
               q   = NIB_W'(m);
               sub = mult[m];
            end
         end
         rem = NIB_W'(part - sub);
         quo[DIV_CHUNK_W-1-s*NIB_W -: NIB_W] = q;
      end
      rem_out = rem;
   end

endmodule

// ===== rtl/ppr_free_pick.sv =====
// Unrank selector: sixteen lanes find the n-th still-free cell of the board.
// Depends on ppr_pkg for widths, pop16 and pick_type.
module ppr_free_pick #(
   parameter int CELLS = ppr_pkg::CELLS_DEFAULT
) (
   input  logic [ppr_pkg::MASK_W-1:0] used,
   input  logic [ppr_pkg::NIB_W-1:0]  digit,
   output ppr_pkg::pick_type          pick
);
   import ppr_pkg::*;

   logic [MASK_W-1:0] free;
   logic [MASK_W-1:0] hit;

   always_comb begin
      for (int c = 0; c < MASK_W; c++) free[c] = !used[c] && (c < CELLS);
      for (int c = 0; c < MASK_W; c++) begin
         hit[c] = free[c] &&
                  (pop16(free & ((MASK_W'(1) << c) - MASK_W'(1))) == {1'b0, digit});
      end
      pick.onehot = hit;
      pick.pos    = '0;
      for (int c = 0; c < MASK_W; c++) begin
         if (hit[c]) pick.pos = pick.pos | NIB_W'(c);
      end
   end

endmodule

// ===== rtl/partial_permutation_rank_codec.sv =====
// Rank mode takes Lehmer digits from the lanes, then folds them in the Horner step; unrank
// mode divides the rank down to digits, then places the cells. The Horner multiplier folds one
// radix per cycle, the divider runs DIV_ROUNDS chunk rounds per digit and the free-cell
// selector picks the cell of each position in turn. Items are worked one at a time.
// Reset (synchronous, active high) returns the controller to idle and empties the output
// register; no storage needs clearing.
`include "partial_permutation_rank_codec_defines.svh"

module partial_permutation_rank_codec #(
   parameter int CELLS = ppr_pkg::CELLS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppr_pkg::REQ_DATA_W-1:0]  req_tdata,  // count[4:0], cells_in, rank_in
   input  logic [0:0]                      req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppr_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // rank_out[44:0], cells_out
   output logic [0:0]                      rsp_tuser   // bad_input
);
   import ppr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LANES  = 6'b000010,
      S_HORNER = 6'b000100,
      S_DIV    = 6'b001000,
      S_PICK   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   localparam logic [COUNT_W-1:0] CellsN  = COUNT_W'(CELLS);
   localparam logic [1:0]         DivLast = 2'(DIV_ROUNDS - 1);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic                   func_ff, func_in;
   logic [COUNT_W-1:0]     n_ff, n_in;
   logic [POS_W-1:0]       cells_ff, cells_in;
   logic [RANK_PAD_W-1:0]  dq_ff, dq_in;
   logic [NIB_W-1:0]       rem_ff, rem_in;
   logic [1:0]             sub_ff, sub_in;
   logic [NIB_W-1:0]       idx_ff, idx_in;
   logic [POS_W-1:0]       sr_ff, sr_in;
   logic [RANK_W-1:0]      r_ff, r_in;
   logic [POS_W-1:0]       cres_ff, cres_in;
   logic [MASK_W-1:0]      used_ff, used_in;
   logic                   bad_ff, bad_in;
   logic [RANK_W-1:0]      rsp_rank_ff, rsp_rank_in;
   logic [POS_W-1:0]       rsp_cells_ff, rsp_cells_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   logic [COUNT_W-1:0]     req_count;
   logic [COUNT_W-1:0]     n_clamp;
   logic [COUNT_W-1:0]     radix;
   logic [RANK_W+COUNT_W-1:0] horner_prod;
   logic                   last_step;
   logic                   can_load;
   logic                   start_div;
   logic                   rank_busy;
   logic [NIB_W-1:0]       rem_next;
   logic [DIV_CHUNK_W-1:0] quo;
   logic [RANK_PAD_W-1:0]  dq_next;
   rank_lanes_type         lanes;
   pick_type               pick;

   assign req_count   = req_tdata[COUNT_W-1:0];
   assign n_clamp     = (req_count > CellsN) ? CellsN : req_count;
   // radix of the Horner step and divisor of the division share the position count
   assign radix       = CellsN - {1'b0, idx_ff};
   assign horner_prod = r_ff * radix;
   assign last_step   = ({1'b0, idx_ff} == (n_ff - COUNT_W'(1)));
   assign can_load    = !rsp_valid_ff || rsp_tready;
   assign dq_next     = {dq_ff[RANK_PAD_W-DIV_CHUNK_W-1:0], quo};
   assign start_div   = req_tready && req_tvalid && req_tuser[0] && (n_clamp != '0);
   assign rank_busy   = (state_ff == S_LANES) || (state_ff == S_HORNER);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_cells_ff, rsp_rank_ff});
   assign rsp_tuser  = rsp_bad_ff;

   ppr_rank_lanes #(.CELLS(CELLS)) u_lanes (
      .cells (cells_ff),
      .count (n_ff),
      .lanes (lanes)
   );

   ppr_div_step u_div (
      .rem_in  (rem_ff),
      .chunk   (dq_ff[RANK_PAD_W-1 -: DIV_CHUNK_W]),
      .divisor (radix),
      .rem_out (rem_next),
      .quo     (quo)
   );

   ppr_free_pick #(.CELLS(CELLS)) u_pick (
      .used  (used_ff),
      .digit (sr_ff[NIB_W-1:0]),
      .pick  (pick)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      func_in      = func_ff;
      n_in         = n_ff;
      cells_in     = cells_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      sub_in       = sub_ff;
      idx_in       = idx_ff;
      sr_in        = sr_ff;
      r_in         = r_ff;
      cres_in      = cres_ff;
      used_in      = used_ff;
      bad_in       = bad_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser[0];
               n_in     = n_clamp;
               cells_in = req_tdata[COUNT_W +: POS_W];
               dq_in    = RANK_PAD_W'(req_tdata[COUNT_W+POS_W +: RANK_W]);
               rem_in   = '0;
               sub_in   = '0;
               idx_in   = req_tuser[0] ? NIB_W'(n_clamp - COUNT_W'(1)) : '0;
               r_in     = '0;
               cres_in  = '0;
               used_in  = '0;
               bad_in   = 1'b0;
               if (n_clamp == '0) begin
                  state_in = S_DONE;
               end else if (req_tuser[0]) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_LANES;
               end
            end
         end
         S_LANES: begin
            sr_in    = lanes.digits;
            bad_in   = lanes.bad;
            idx_in   = '0;
            state_in = S_HORNER;
         end
         S_HORNER: begin
            r_in   = RANK_W'(horner_prod) + RANK_W'(sr_ff[NIB_W-1:0]);
            sr_in  = sr_ff >> NIB_W;
            idx_in = idx_ff + NIB_W'(1);
            if (last_step) state_in = S_DONE;
         end
         S_DIV: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == DivLast) begin
               // digit complete: push it in below, so digit 0 ends up lowest
               sub_in = '0;
               rem_in = '0;
               sr_in  = {sr_ff[POS_W-NIB_W-1:0], rem_next};
               if (idx_ff == '0) begin
                  bad_in   = (dq_next != '0);
                  state_in = S_PICK;
               end else begin
                  idx_in = idx_ff - NIB_W'(1);
               end
            end
         end
         S_PICK: begin
            cres_in[{idx_ff, 2'b00} +: NIB_W] = pick.pos;
            used_in = used_ff | pick.onehot;
            sr_in   = sr_ff >> NIB_W;
            idx_in  = idx_ff + NIB_W'(1);
            if (last_step) state_in = S_DONE;
         end
         S_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = r_ff;
               rsp_cells_in = cres_ff;
               rsp_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      n_ff         <= n_in;
      cells_ff     <= cells_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      sub_ff       <= sub_in;
      idx_ff       <= idx_in;
      sr_ff        <= sr_in;
      r_ff         <= r_in;
      cres_ff      <= cres_in;
      used_ff      <= used_in;
      bad_ff       <= bad_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   `PPR_ASSERT_IMP(a_div_rem_below, (state_ff == S_DIV), ({1'b0, rem_ff} < radix), "bad remainder")
   `PPR_ASSERT_IMP(a_pick_onehot, (state_ff == S_PICK), $onehot(pick.onehot), "pick not one-hot")
   `PPR_ASSERT_IMP(a_pick_free, (state_ff == S_PICK), (~|(pick.onehot & used_ff)), "reused cell")
   `PPR_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "stray beat")
   `PPR_ASSERT_NXT(a_unrank_mode, start_div, (state_ff == S_DIV), "divider not started")

   // func_ff records the mode of the item in flight
   `PPR_ASSERT_IMP(a_mode_path, rank_busy, !func_ff, "rank path entered in unrank mode")

endmodule
